// ===== sv/array_list_engine_macros.svh =====
// assertion helpers shared by the array list engine
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ALE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array list engine check failed");

// next-cycle implication, checked outside reset
`define ALE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array list engine check failed");

`endif

// ===== sv/ale_pkg.sv =====
`default_nettype none

package ale_pkg;

  // widths of the word fields
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int FILL_W   = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  // per-cell update controls
  typedef struct packed {
    logic load;   // take the broadcast key
    logic shift;  // take the right neighbor's value
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/ale_cell.sv =====
`default_nettype none

// one list slot: holds a value, compares it with the key, shifts from its neighbor
module ale_cell (
  input  wire                         clk,
  input  wire  ale_pkg::cell_ctrl_t   ctrl,
  input  wire  [ale_pkg::VALUE_W-1:0] key,
  input  wire  [ale_pkg::VALUE_W-1:0] right_value,
  output logic [ale_pkg::VALUE_W-1:0] value,
  output logic                        hit
);
  import ale_pkg::*;

  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;

  // load, shift toward the front, or hold
  always_comb begin
    priority if (ctrl.load) begin
      value_nxt = key;
    end else if (ctrl.shift) begin
      value_nxt = right_value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign hit   = (value_r == key);

endmodule

`default_nettype wire

// ===== sv/array_list_engine.sv =====
// array list engine: an ordered list of up to CAPACITY signed 32-bit values.
// input channel in_*: in_tuser carries the command (insert, search, delete),
// in_tdata the value. result channel out_*: one word per input word, with
// status, position, fill count and empty/full flags.
// the list lives in a row of CAPACITY cells. insert writes the cell at the
// fill count in one step. search and delete walk a scan pointer along the row,
// one cell per cycle, until the first match or the fill count; a delete then
// shifts every later cell one place toward the front in the same cycle.
// an accepted word goes from idle to the scan state, then to the wait state, which
// loads the result into the output register. insert, a delete from an empty list
// and the unused command leave the scan state at once; search and delete stay in
// it while the scan pointer walks the cell row. the next word is taken only after
// the result is loaded, so the engine works on one word at a time.
// reset empties the list (fill count zero); cell contents need no reset.
// when the receiver stalls, the result waits in the output register and the
// block still accepts and works on the next word; that word's result then
// waits in the engine until the output register frees.
`default_nettype none

`include "array_list_engine_macros.svh"

module array_list_engine #(
  parameter int CAPACITY = 128
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  input  wire  [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [8:2] position, [16:9] fill_count,
                                  // [17] is_empty, [18] is_full, [23:19] zero
);
  import ale_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // engine states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [VALUE_W-1:0]  key_r, key_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [POS_W-1:0]    res_pos_r, res_pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;

  logic                do_insert;
  logic                do_delete;
  logic                in_take;
  logic                out_free;
  logic                scan_end;
  logic                scan_hit;

  cell_ctrl_t          ctrl [CAPACITY];
  logic [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0] hit;

  // wrap a count or index to the position field
  function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
    logic [CW+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, v};
    return ext[POS_W-1:0];
  endfunction

  // wrap the count to the fill field
  function automatic logic [FILL_W-1:0] to_fill(input logic [CW-1:0] v);
    logic [CW+FILL_W-1:0] ext;
    ext = {{FILL_W{1'b0}}, v};
    return ext[FILL_W-1:0];
  endfunction

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] right_value;
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    assign ctrl[i].load  = do_insert && (count_r == CW'(i));
    assign ctrl[i].shift = do_delete && (CW'(i) >= scan_r) && (CW'(i + 1) < count_r);

    ale_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .key         (key_r),
      .right_value (right_value),
      .value       (cell_value[i]),
      .hit         (hit[i])
    );
  end

  // handshake and scan decode
  assign in_tready = (state_r == ST_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_end  = (scan_r == count_r);
  assign scan_hit  = !scan_end && hit[scan_r[IW-1:0]];
  assign do_insert = (state_r == ST_SCAN) && (cmd_r == CMD_INSERT) && (count_r != CAP_CNT);
  assign do_delete = (state_r == ST_SCAN) && (cmd_r == CMD_DELETE) && scan_hit;

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd_nxt   = in_tuser;
          key_nxt   = in_tdata;
          scan_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_status_nxt = STAT_OK;
        res_pos_nxt    = '0;
        state_nxt      = ST_WAIT;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (count_r == CAP_CNT) begin
              res_status_nxt = STAT_FULL;
            end else begin
              res_pos_nxt = to_pos(count_r);
              count_nxt   = count_r + CW'(1);
            end
          end
          CMD_SEARCH, CMD_DELETE: begin
            priority if (cmd_r == CMD_DELETE && count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
            end else if (scan_end) begin
              res_status_nxt = STAT_NOTFOUND;
            end else if (scan_hit) begin
              res_pos_nxt = to_pos(scan_r);
              if (cmd_r == CMD_DELETE) begin
                count_nxt = count_r - CW'(1);
              end
            end else begin
              scan_nxt  = scan_r + CW'(1);
              state_nxt = ST_SCAN;
            end
          end
          CMD_NOP: begin
            res_status_nxt = STAT_OK;
          end
          default: begin
            res_status_nxt = STAT_OK;
          end
        endcase
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0,
                           (count_r >= CAP_CNT),
                           (count_r == '0),
                           to_fill(count_r),
                           res_pos_r,
                           res_status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ALE_ASSERT_NEXT(a_count_only_in_scan, state_r != ST_SCAN, $stable(count_r))
  `ALE_ASSERT_NOW(a_count_bounded, state_r == ST_SCAN, count_r <= CAP_CNT)
  `ALE_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN, scan_r <= count_r)
  `ALE_ASSERT_NOW(a_full_means_cap, state_r == ST_WAIT && res_status_r == STAT_FULL,
                  count_r == CAP_CNT)

endmodule

`default_nettype wire
